@@ design/dsbd_pkg.sv @@
// Shared constants, types and codes for the drop sensor baseline detector.
// No dependencies; every other file of the block depends on this package.
package dsbd_pkg;

	localparam int CHANNELS      = 4;
	localparam int SAMPLE_FIELDS = 4;
	localparam int SMP_W         = 12;
	localparam int ACC_W         = 32;
	localparam int CNT_W         = 19;
	localparam int MASK_W        = 4;
	localparam int OP_W          = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int DIGIT_W       = 8;
	localparam int ACC_DIGITS    = ACC_W / DIGIT_W;
	localparam int DIG_CNT_W     = (ACC_DIGITS > 1) ? $clog2(ACC_DIGITS) : 1;
	localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIV_STEP_W    = $clog2(ACC_W);

	localparam logic [CNT_W-1:0] COUNT_LIMIT = 19'h7FFFF;

	localparam logic [SMP_W-1:0] REF_LEVEL_RESET  = 12'd1110;
	localparam logic [SMP_W-1:0] ACCEPT_TOL_RESET = 12'd600;
	localparam logic [SMP_W-1:0] RISE_LIMIT_RESET = 12'd600;
	localparam logic [SMP_W-1:0] FALL_LIMIT_RESET = 12'd800;

	typedef logic [SMP_W-1:0] sample_t;
	typedef logic [ACC_W-1:0] acc_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUMULATE = 2'd0,
		OP_FINALIZE   = 2'd1,
		OP_DETECT     = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF_LEVEL  = 2'd0,
		REG_ACCEPT_TOL = 2'd1,
		REG_RISE_LIMIT = 2'd2,
		REG_FALL_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		sample_t ref_level;
		sample_t accept_tolerance;
		sample_t rise_limit;
		sample_t fall_limit;
	} cfg_t;

	typedef struct packed {
		logic acc_load;
		logic acc_step;
		logic det_capture;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DET
	} state_t;

endpackage

@@ design/dsbd_stream_if.sv @@
// Valid/ready stream interfaces for the sample and result channels.
// Depends on dsbd_pkg for field widths.
interface dsbd_in_if;
	logic valid;
	logic ready;
	logic [dsbd_pkg::OP_W-1:0] opcode;
	dsbd_pkg::sample_t sample_ch0;
	dsbd_pkg::sample_t sample_ch1;
	dsbd_pkg::sample_t sample_ch2;
	dsbd_pkg::sample_t sample_ch3;

	modport source (output valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		input ready);
	modport sink (input valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
		output ready);
endinterface

interface dsbd_out_if;
	logic valid;
	logic ready;
	logic [dsbd_pkg::MASK_W-1:0] drop_mask;

	modport source (output valid, drop_mask, input ready);
	modport sink (input valid, drop_mask, output ready);
endinterface

@@ design/dsbd_div.sv @@
// Restoring divider, one quotient bit per cycle; the dividend shifts out MSB first.
// Depends on dsbd_pkg.
module dsbd_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dsbd_pkg::acc_t   dividend,
	input  dsbd_pkg::count_t divisor,
	output logic            done,
	output dsbd_pkg::acc_t   quotient
);
	import dsbd_pkg::*;

	acc_t                  dvd_q;
	count_t                rem_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        diff;
	logic                  fits;

	always_comb begin
		trial = {rem_q, dvd_q[ACC_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_STEP_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ design/dsbd_lane.sv @@
// One channel: digit-serial accumulator, previous sample and window compare.
// Depends on dsbd_pkg.
module dsbd_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsbd_pkg::lane_ctrl_t ctrl,
	input  dsbd_pkg::cfg_t       cfg,
	input  dsbd_pkg::sample_t    sample,
	input  logic                 quot_wr,
	input  dsbd_pkg::acc_t       quot,
	output dsbd_pkg::acc_t       acc,
	output logic                 drop
);
	import dsbd_pkg::*;

	acc_t            acc_q;
	acc_t            add_q;
	logic            carry_q;
	sample_t         prev_q;
	sample_t         avg_s1;
	sample_t         deviation;
	sample_t         addend;
	logic [DIGIT_W:0] digit_sum;
	logic [SMP_W:0]  pair_sum;
	logic [SMP_W:0]  hi;
	sample_t         lo;
	logic            lo_ok;
	logic            flag_hi;
	logic            flag_lo;

	always_comb begin
		deviation = (sample > cfg.ref_level) ? sample - cfg.ref_level
			: cfg.ref_level - sample;
		addend    = (deviation < cfg.accept_tolerance) ? sample : cfg.ref_level;
		digit_sum = {1'b0, acc_q[DIGIT_W-1:0]} + {1'b0, add_q[DIGIT_W-1:0]}
			+ {{DIGIT_W{1'b0}}, carry_q};
		pair_sum  = {1'b0, prev_q} + {1'b0, sample};
		// baseline - avg > rise  <=>  baseline > avg + rise
		hi        = {1'b0, avg_s1} + {1'b0, cfg.rise_limit};
		// baseline - avg < -fall  <=>  baseline < avg - fall, only possible when avg > fall
		lo_ok     = avg_s1 > cfg.fall_limit;
		lo        = avg_s1 - cfg.fall_limit;
		flag_hi   = (acc_q[ACC_W-1:SMP_W+1] != '0) || (acc_q[SMP_W:0] > hi);
		flag_lo   = lo_ok && (acc_q[ACC_W-1:SMP_W] == '0) && (acc_q[SMP_W-1:0] < lo);
		drop      = flag_hi || flag_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			carry_q <= 1'b0;
			prev_q  <= '0;
		end else begin
			if (quot_wr) begin
				acc_q  <= quot;
				prev_q <= quot[SMP_W-1:0];
			end else if (ctrl.acc_step) begin
				// rotate one digit per cycle, least significant first
				acc_q   <= {digit_sum[DIGIT_W-1:0], acc_q[ACC_W-1:DIGIT_W]};
				carry_q <= digit_sum[DIGIT_W];
			end
			if (ctrl.acc_load) begin
				carry_q <= 1'b0;
			end
			if (ctrl.det_capture) begin
				prev_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_load) begin
			add_q <= {{(ACC_W-SMP_W){1'b0}}, addend};
		end else if (ctrl.acc_step) begin
			add_q <= add_q >> DIGIT_W;
		end
		if (ctrl.det_capture) begin
			avg_s1 <= pair_sum[SMP_W:1];
		end
	end

	assign acc = acc_q;

endmodule

@@ design/drop_sensor_baseline_detector_core.sv @@
// Drop sensor baseline detector: sequencer, configuration registers and result register.
// Depends on dsbd_pkg, dsbd_stream_if, dsbd_lane and dsbd_div.
//
// One transaction at a time. Accumulate steps through ST_ACC before the next
// acceptance: the 32-bit channel accumulators add in four 8-bit digits, all channels
// side by side. Detect leaves its mask in the result register, holding in ST_DET
// for as long as a previous mask has not yet been taken. Finalize runs the shared
// bit-serial divider once per channel, 32 steps each; a finalize that has no effect
// is accepted and dropped, like any ignored opcode.
// Register writes apply immediately and must only be issued while the block is idle.
module drop_sensor_baseline_detector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	dsbd_in_if.sink                        samples,
	dsbd_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [dsbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  dsbd_pkg::sample_t              cfg_data
);
	import dsbd_pkg::*;

	state_t              state_q;
	state_t              state_nxt;
	cfg_t                cfg_q;
	count_t              count_q;
	logic                cal_q;
	logic [CH_W-1:0]     ch_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   out_mask_q;

	logic                in_ready;
	logic                in_acc;
	logic                acc_ok;
	logic                fin_ok;
	logic                out_free;
	logic                out_load;
	logic                div_start;
	logic                div_commit;
	logic                div_done;
	logic                last_ch;
	lane_ctrl_t          lane_ctrl;
	acc_t                quotient;
	acc_t                dividend;
	logic [MASK_W-1:0]   mask;
	op_t                 op;

	sample_t             fields [SAMPLE_FIELDS];
	sample_t             smp    [CHANNELS];
	acc_t                acc_w  [CHANNELS];
	logic [CHANNELS-1:0] drop_w;
	logic [CHANNELS-1:0] quot_wr;

	assign fields[0] = samples.sample_ch0;
	assign fields[1] = samples.sample_ch1;
	assign fields[2] = samples.sample_ch2;
	assign fields[3] = samples.sample_ch3;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			smp[i] = (i < SAMPLE_FIELDS) ? fields[i] : '0;
		end
	end

	assign op       = op_t'(samples.opcode);
	assign acc_ok   = !cal_q && (count_q < COUNT_LIMIT);
	assign fin_ok   = !cal_q && (count_q != '0);
	assign out_free = !out_valid_q || result.ready;
	assign last_ch  = ch_q == CH_W'(CHANNELS - 1);
	assign dividend = acc_w[ch_q];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op)
						OP_ACCUMULATE: if (acc_ok) state_nxt = ST_ACC;
						OP_FINALIZE:   if (fin_ok) state_nxt = ST_DIV_START;
						OP_DETECT:     state_nxt = ST_DET;
						default:       state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ACC: begin
				if (dig_q == DIG_CNT_W'(ACC_DIGITS - 1)) state_nxt = ST_IDLE;
			end
			ST_DIV_START: state_nxt = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_nxt = last_ch ? ST_IDLE : ST_DIV_START;
			end
			ST_DET: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready              = state_q == ST_IDLE;
		in_acc                = samples.valid && in_ready;
		lane_ctrl.acc_load    = in_acc && (op == OP_ACCUMULATE) && acc_ok;
		lane_ctrl.acc_step    = state_q == ST_ACC;
		lane_ctrl.det_capture = in_acc && (op == OP_DETECT);
		div_start             = state_q == ST_DIV_START;
		div_commit            = (state_q == ST_DIV_WAIT) && div_done;
		out_load              = (state_q == ST_DET) && out_free;
	end

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			quot_wr[i] = div_commit && (ch_q == CH_W'(i));
		end
		mask = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (i < MASK_W) mask[i] = drop_w[i];
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		dsbd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.cfg     (cfg_q),
			.sample  (smp[g]),
			.quot_wr (quot_wr[g]),
			.quot    (quotient),
			.acc     (acc_w[g]),
			.drop    (drop_w[g])
		);
	end

	dsbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cal_q       <= 1'b0;
			ch_q        <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
			cfg_q.ref_level        <= REF_LEVEL_RESET;
			cfg_q.accept_tolerance <= ACCEPT_TOL_RESET;
			cfg_q.rise_limit       <= RISE_LIMIT_RESET;
			cfg_q.fall_limit       <= FALL_LIMIT_RESET;
		end else begin
			state_q <= state_nxt;
			if (lane_ctrl.acc_load) begin
				count_q <= count_q + 1'b1;
				dig_q   <= '0;
			end else if (lane_ctrl.acc_step) begin
				dig_q <= dig_q + 1'b1;
			end
			if (state_q == ST_IDLE) begin
				ch_q <= '0;
			end else if (div_commit) begin
				ch_q <= ch_q + 1'b1;
				if (last_ch) cal_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_REF_LEVEL:  cfg_q.ref_level        <= cfg_data;
					REG_ACCEPT_TOL: cfg_q.accept_tolerance <= cfg_data;
					REG_RISE_LIMIT: cfg_q.rise_limit       <= cfg_data;
					REG_FALL_LIMIT: cfg_q.fall_limit       <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_mask_q <= mask;
	end

	assign samples.ready    = in_ready;
	assign result.valid     = out_valid_q;
	assign result.drop_mask = out_mask_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> count_q != '0)
		else $error("divider started with zero count");

	a_no_acc_after_cal: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ctrl.acc_step |-> !cal_q)
		else $error("accumulator stepped after finalize");

	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q |=> cal_q)
		else $error("calibrated flag dropped");

	a_result_from_detect: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DET))
		else $error("result loaded outside detect");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= CH_W'(CHANNELS - 1))
		else $error("channel index out of range");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for drop_sensor_baseline_detector_core.
// Depends on dsbd_pkg and the stream interfaces; predicts each drop mask from
// a shadow of the accumulators, previous samples and thresholds.
module tb;
	import dsbd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_MAX    = 10;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	reg_idx_t cfg_index;
	sample_t  cfg_data;

	dsbd_in_if  smp_if();
	dsbd_out_if res_if();

	drop_sensor_baseline_detector_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the block state
	cfg_t    shadow_cfg;
	acc_t    base_sum [CHANNELS];
	sample_t last_smp [CHANNELS];
	count_t  item_count;
	logic    calibrated_q;

	logic [MASK_W-1:0] masks_due [$];
	logic [MASK_W-1:0] due_mask;

	int failures     = 0;
	int cycles       = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_request = 0;
	int hold_left    = 0;

	task automatic track_item();
		logic [OP_W-1:0]   op;
		sample_t           cur [CHANNELS];
		sample_t           dev;
		logic [SMP_W:0]    avg;
		longint            diff;
		logic [MASK_W-1:0] mask;
		op     = smp_if.opcode;
		cur[0] = smp_if.sample_ch0;
		cur[1] = smp_if.sample_ch1;
		cur[2] = smp_if.sample_ch2;
		cur[3] = smp_if.sample_ch3;
		mask   = '0;
		case (op)
			OP_ACCUMULATE: begin
				if (!calibrated_q && item_count < COUNT_LIMIT) begin
					for (int ch = 0; ch < CHANNELS; ch++) begin
						dev = (cur[ch] > shadow_cfg.ref_level) ? cur[ch] - shadow_cfg.ref_level
							: shadow_cfg.ref_level - cur[ch];
						// substitute the reference for samples outside tolerance
						base_sum[ch] += (dev < shadow_cfg.accept_tolerance) ? acc_t'(cur[ch])
							: acc_t'(shadow_cfg.ref_level);
					end
					item_count = item_count + 1'b1;
				end
			end
			OP_FINALIZE: begin
				if (!calibrated_q && item_count != '0) begin
					for (int ch = 0; ch < CHANNELS; ch++) begin
						base_sum[ch] = base_sum[ch] / acc_t'(item_count);
						last_smp[ch] = base_sum[ch][SMP_W-1:0];
					end
					calibrated_q = 1'b1;
				end
			end
			OP_DETECT: begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					avg  = ({1'b0, last_smp[ch]} + {1'b0, cur[ch]}) >> 1;
					diff = longint'({32'd0, base_sum[ch]}) - longint'(avg);
					last_smp[ch] = cur[ch];
					if (diff > longint'(shadow_cfg.rise_limit)
							|| diff < -longint'(shadow_cfg.fall_limit))
						mask[ch] = 1'b1;
				end
				masks_due.push_back(mask);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && smp_if.valid && smp_if.ready)
			track_item();
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (masks_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("drop mask %h arrived with none outstanding", res_if.drop_mask);
			end else begin
				due_mask = masks_due.pop_front();
				if (res_if.drop_mask !== due_mask) begin
					failures++;
					if (failures <= REPORT_MAX)
						$display("drop mask mismatch: expected %h, got %h",
							due_mask, res_if.drop_mask);
				end
			end
		end
	end

	// Result side: random hold-off, or a long stall on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input sample_t s0, input sample_t s1,
			input sample_t s2, input sample_t s3);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid      <= 1'b1;
		smp_if.opcode     <= op;
		smp_if.sample_ch0 <= s0;
		smp_if.sample_ch1 <= s1;
		smp_if.sample_ch2 <= s2;
		smp_if.sample_ch3 <= s3;
		do @(posedge clk); while (!smp_if.ready);
	endtask

	// Drop valid, drain outstanding masks and let a finalize finish
	task automatic settle_block();
		smp_if.valid <= 1'b0;
		while (masks_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_thresholds(input sample_t lvl, input sample_t tol,
			input sample_t rise, input sample_t fall);
		reg_idx_t order [4] = '{REG_REF_LEVEL, REG_ACCEPT_TOL, REG_RISE_LIMIT, REG_FALL_LIMIT};
		sample_t  vals  [4];
		settle_block();
		vals = '{lvl, tol, rise, fall};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		shadow_cfg.ref_level        = lvl;
		shadow_cfg.accept_tolerance = tol;
		shadow_cfg.rise_limit       = rise;
		shadow_cfg.fall_limit       = fall;
	endtask

	function automatic sample_t rand_near(input int centre, input int spread);
		int v;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return sample_t'(v);
	endfunction

	function automatic sample_t rand_sample();
		return sample_t'($urandom_range(0, 4095));
	endfunction

	function automatic sample_t pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return sample_t'($urandom_range(0, 1500));
	endfunction

	function automatic logic [OP_W-1:0] pick_noise_op(input logic calibrated);
		int r;
		r = $urandom_range(0, 2);
		// before calibration only harmless codes may pass as noise
		if (!calibrated || r == 2)
			return OP_UNUSED;
		return (r == 0) ? OP_ACCUMULATE : OP_FINALIZE;
	endfunction

	// Reset values, empty accumulators, finalize with nothing summed
	task automatic test_uncalibrated();
		send_item(OP_DETECT, 12'd0, 12'd4095, 12'd0, 12'd4095);
		send_item(OP_DETECT, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_item(OP_FINALIZE, rand_sample(), rand_sample(), rand_sample(), rand_sample());
		send_item(OP_UNUSED, rand_sample(), rand_sample(), rand_sample(), rand_sample());
		send_item(OP_DETECT, 12'd0, 12'd2048, 12'd1, 12'd4094);
	endtask

	// Tolerance edges: just inside, exactly at, zero and full-scale tolerance
	task automatic test_accumulate_edges();
		load_thresholds(12'd1000, 12'd100, 12'd600, 12'd800);
		send_item(OP_ACCUMULATE, 12'd1000, 12'd1099, 12'd1100, 12'd901);
		send_item(OP_ACCUMULATE, 12'd0, 12'd4095, 12'd900, 12'd1101);
		load_thresholds(12'd1000, 12'd0, 12'd600, 12'd800);
		send_item(OP_ACCUMULATE, 12'd1000, 12'd1000, 12'd5, 12'd4000);
		load_thresholds(12'd4095, 12'd4095, 12'd0, 12'd4095);
		send_item(OP_ACCUMULATE, 12'd0, 12'd4095, 12'd2048, 12'd17);
		load_thresholds(12'd0, 12'd4095, 12'd4095, 12'd0);
		send_item(OP_ACCUMULATE, 12'd4095, 12'd0, 12'd1, 12'd4094);
		send_item(OP_DETECT, 12'd4095, 12'd0, 12'd4095, 12'd0);
	endtask

	task automatic test_calibrate_random(input int n);
		int      lvl;
		int      tol;
		int      r;
		sample_t s [4];
		for (int i = 0; i < n; i++) begin
			if (i % 15 == 0) begin
				lvl = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
					: $urandom_range(300, 3800);
				tol = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
					: $urandom_range(1, 900);
				load_thresholds(sample_t'(lvl), sample_t'(tol), pick_limit(), pick_limit());
			end
			for (int ch = 0; ch < 4; ch++)
				s[ch] = ($urandom_range(0, 3) == 0) ? rand_sample()
					: rand_near(lvl, 2 * tol + 10);
			r = $urandom_range(0, 9);
			if (r < 7)
				send_item(OP_ACCUMULATE, s[0], s[1], s[2], s[3]);
			else if (r < 9)
				send_item(OP_DETECT, s[0], s[1], s[2], s[3]);
			else
				send_item(OP_UNUSED, s[0], s[1], s[2], s[3]);
		end
	endtask

	// Finalize takes effect once; later accumulate and finalize are ignored
	task automatic test_finalize_once();
		sample_t b [4];
		settle_block();
		send_item(OP_FINALIZE, 12'd0, 12'd0, 12'd0, 12'd0);
		send_item(OP_FINALIZE, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_item(OP_ACCUMULATE, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		load_thresholds(shadow_cfg.ref_level, shadow_cfg.accept_tolerance, 12'd0, 12'd0);
		for (int ch = 0; ch < 4; ch++)
			b[ch] = base_sum[ch][SMP_W-1:0];
		send_item(OP_DETECT, b[0], b[1], b[2], b[3]);
		send_item(OP_DETECT, rand_near(b[0] + 1, 0), rand_near(b[1] + 1, 0),
			rand_near(b[2] + 1, 0), rand_near(b[3] + 1, 0));
		load_thresholds(12'd4095, 12'd0, 12'd4095, 12'd4095);
		send_item(OP_DETECT, 12'd0, 12'd4095, 12'd0, 12'd4095);
		send_item(OP_DETECT, 12'd4095, 12'd0, 12'd4095, 12'd0);
	endtask

	task automatic test_detect_random(input int n);
		sample_t s [4];
		int      spread;
		int      count;
		count = 0;
		while (count < n) begin
			if (count % 50 == 0)
				load_thresholds(rand_sample(), rand_sample(), pick_limit(), pick_limit());
			spread = $urandom_range(50, 2000);
			for (int ch = 0; ch < 4; ch++)
				s[ch] = ($urandom_range(0, 3) == 0) ? rand_sample()
					: rand_near(base_sum[ch][SMP_W-1:0], spread);
			if ($urandom_range(0, 9) == 0) begin
				send_item(pick_noise_op(1'b1), s[0], s[1], s[2], s[3]);
			end else begin
				send_item(OP_DETECT, s[0], s[1], s[2], s[3]);
				count++;
			end
		end
	endtask

	// Hold the result side off long enough for the block to back up its input
	task automatic test_backpressure(input int n);
		settle_block();
		hold_request = 400;
		for (int i = 0; i < n; i++)
			send_item(OP_DETECT, rand_sample(), rand_sample(), rand_sample(), rand_sample());
	endtask

	task automatic finish_run();
		smp_if.valid <= 1'b0;
		while (masks_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		failures += masks_due.size();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_REF_LEVEL;
		cfg_data          <= '0;
		smp_if.valid      <= 1'b0;
		smp_if.opcode     <= OP_ACCUMULATE;
		smp_if.sample_ch0 <= '0;
		smp_if.sample_ch1 <= '0;
		smp_if.sample_ch2 <= '0;
		smp_if.sample_ch3 <= '0;
		shadow_cfg   = '{REF_LEVEL_RESET, ACCEPT_TOL_RESET, RISE_LIMIT_RESET, FALL_LIMIT_RESET};
		item_count   = '0;
		calibrated_q = 1'b0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			base_sum[ch] = '0;
			last_smp[ch] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 11;
		recv_gap_pct = 68;
		test_uncalibrated();
		test_accumulate_edges();
		test_calibrate_random(80);
		test_finalize_once();
		test_detect_random(220);

		send_gap_pct = 68;
		recv_gap_pct = 11;
		test_detect_random(220);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_detect_random(180);
		test_backpressure(40);

		finish_run();
	end

endmodule

@@ drop_sensor_baseline_detector_core.f @@
design/dsbd_pkg.sv
design/dsbd_stream_if.sv
design/dsbd_div.sv
design/dsbd_lane.sv
design/drop_sensor_baseline_detector_core.sv
verif/tb.sv
